>>> rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen at a clock edge
`define CHK_NEVER(lbl, clk, rst_n, expr, msg) \
    `CHK_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

>>> rtl/core/rmrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmrf_pkg;

    localparam int SPAN_BITS = 7;
    localparam logic [SPAN_BITS-1:0] SPAN_RESET = 7'd30;

    // broadcast from the top level to every cell of the sorted row
    typedef struct packed {
        logic step;      // an item is taken this cycle
        logic full;      // window already full: one entry leaves, one enters
        logic merge_up;  // full and the new sample is not below the leaving one
    } rmrf_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/rmrf_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rmrf_sample_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          record_start;

    modport source (output valid, sample, record_start, input ready);
    modport sink (input valid, sample, record_start, output ready);
endinterface

interface rmrf_result_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS:0]   residual;
    logic signed [SAMPLE_BITS-1:0] median;
    logic signed [SAMPLE_BITS-1:0] centre;

    modport source (output valid, residual, median, centre, input ready);
    modport sink (input valid, residual, median, centre, output ready);
endinterface

interface rmrf_cfg_if
    import rmrf_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [SPAN_BITS-1:0] half_span;

    modport source (output valid, half_span, input ready);
    modport sink (input valid, half_span, output ready);
endinterface

`default_nettype wire

>>> rtl/core/running_median_residual_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// channel     dir  payload
// sample_ch   in   sample, record_start
// result_ch   out  residual, median, centre
// span_cfg    in   half_span
//
// one sample per cycle: the row of cells removes the oldest entry and inserts
// the new one in the same cycle; a result is held pending, then loaded to the outputs
// the input stalls only while a finished result waits on result_ch
// reset sets half_span to 30 and empties the window; no clearing pass
// the median sits in the middle cell and the centre sample in the middle tap

module running_median_residual_filter
    import rmrf_pkg::*;
#(
    parameter int MAX_HALF_SPAN = 64,
    parameter int SAMPLE_BITS   = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rmrf_sample_if.sink sample_ch,
    rmrf_result_if.source result_ch,
    rmrf_cfg_if.sink    span_cfg
);

    localparam int DEPTH   = 2 * MAX_HALF_SPAN + 1;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int MID     = MAX_HALF_SPAN;
    localparam int LAST    = DEPTH - 1;
    localparam int EFF_RST = (int'(SPAN_RESET) > MAX_HALF_SPAN) ? MAX_HALF_SPAN
                                                                 : int'(SPAN_RESET);
    localparam logic [IDX_W-1:0] MID_I    = IDX_W'(MID);
    localparam logic [IDX_W-1:0] BASE_RST = IDX_W'(MID - EFF_RST);
    localparam logic [CNT_W-1:0] WIN_RST  = CNT_W'(2 * EFF_RST + 1);

    logic [IDX_W-1:0] base_reg;
    logic [IDX_W-1:0] base_next;
    logic [CNT_W-1:0] win_reg;
    logic [CNT_W-1:0] win_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pend_reg;
    logic             pend_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic signed [SAMPLE_BITS:0]   residual_reg;
    logic signed [SAMPLE_BITS-1:0] median_reg;
    logic signed [SAMPLE_BITS-1:0] centre_reg;

    logic [SPAN_BITS-1:0] eff_span;
    logic                 cfg_wr;
    logic                 in_xfer;
    logic                 out_load;
    logic [CNT_W-1:0]     cnt_eff;
    logic [CNT_W-1:0]     cnt_after;
    logic [CNT_W-1:0]     fill_end;
    logic [IDX_W-1:0]     old_base;
    logic                 full;
    logic                 has_result;
    rmrf_ctrl_t           ctrl;

    logic signed [SAMPLE_BITS-1:0] val    [DEPTH];
    logic signed [SAMPLE_BITS-1:0] ctap   [DEPTH];
    logic signed [SAMPLE_BITS-1:0] otap   [DEPTH];
    logic                          le_s   [DEPTH];
    logic                          le_old [DEPTH];

    assign cfg_wr         = span_cfg.valid & span_cfg.ready;
    assign span_cfg.ready = 1'b1;

    // clamp the span into 1..MAX_HALF_SPAN
    always_comb
    begin
        if (span_cfg.half_span == '0)
            eff_span = SPAN_BITS'(1);
        else if ({1'b0, span_cfg.half_span} > (SPAN_BITS + 1)'(MAX_HALF_SPAN))
            eff_span = SPAN_BITS'(MAX_HALF_SPAN);
        else
            eff_span = span_cfg.half_span;
        base_next = MID_I - IDX_W'(eff_span);
        win_next  = CNT_W'({eff_span, 1'b1});
    end

    assign in_xfer         = sample_ch.valid & sample_ch.ready;
    assign out_load        = pend_reg & (~out_valid_reg | result_ch.ready);
    assign sample_ch.ready = ~pend_reg | out_load;

    always_comb
    begin
        cnt_eff    = sample_ch.record_start ? '0 : count_reg;
        full       = (cnt_eff == win_reg);
        cnt_after  = full ? cnt_eff : cnt_eff + CNT_W'(1);
        has_result = (cnt_after == win_reg);
        fill_end   = CNT_W'(base_reg) + cnt_eff;
        old_base   = IDX_W'({base_reg, 1'b0});
    end

    always_comb
    begin
        ctrl.step     = in_xfer;
        ctrl.full     = full;
        ctrl.merge_up = full & (sample_ch.sample >= otap[LAST]);
    end

    always_comb
    begin
        count_next = count_reg;
        if (cfg_wr)
            count_next = '0;
        else if (in_xfer)
            count_next = cnt_after;
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (in_xfer)
            pend_next = has_result;
        else if (out_load)
            pend_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (result_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= BASE_RST;
            win_reg       <= WIN_RST;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                base_reg <= base_next;
                win_reg  <= win_next;
            end
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            median_reg   <= val[MID];
            centre_reg   <= ctap[MID];
            residual_reg <= (SAMPLE_BITS + 1)'(ctap[MID]) - (SAMPLE_BITS + 1)'(val[MID]);
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic signed [SAMPLE_BITS-1:0] below_val;
            logic                          below_le_s;
            logic signed [SAMPLE_BITS-1:0] above_val;
            logic                          above_le_s;
            logic                          above_le_old;
            logic signed [SAMPLE_BITS-1:0] ctap_prev;
            logic signed [SAMPLE_BITS-1:0] otap_prev;

            if (i == 0)
            begin : g_bottom
                assign below_val  = sample_ch.sample;
                assign below_le_s = 1'b1;
                assign ctap_prev  = sample_ch.sample;
                assign otap_prev  = sample_ch.sample;
            end
            else
            begin : g_lower
                assign below_val  = val[i-1];
                assign below_le_s = le_s[i-1];
                assign ctap_prev  = ctap[i-1];
                assign otap_prev  = otap[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_top
                assign above_val    = sample_ch.sample;
                assign above_le_s   = 1'b0;
                assign above_le_old = 1'b0;
            end
            else
            begin : g_upper
                assign above_val    = val[i+1];
                assign above_le_s   = le_s[i+1];
                assign above_le_old = le_old[i+1];
            end

            rmrf_cell #(
                .SAMPLE_BITS(SAMPLE_BITS),
                .IDX_W      (IDX_W),
                .CNT_W      (CNT_W),
                .IDX        (i)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .sample      (sample_ch.sample),
                .oldest      (otap[LAST]),
                .base        (base_reg),
                .old_base    (old_base),
                .fill_end    (fill_end),
                .below_val   (below_val),
                .below_le_s  (below_le_s),
                .above_val   (above_val),
                .above_le_s  (above_le_s),
                .above_le_old(above_le_old),
                .ctap_prev   (ctap_prev),
                .otap_prev   (otap_prev),
                .val         (val[i]),
                .le_s        (le_s[i]),
                .le_old      (le_old[i]),
                .ctap        (ctap[i]),
                .otap        (otap[i])
            );
        end
    endgenerate

    assign result_ch.valid    = out_valid_reg;
    assign result_ch.residual = residual_reg;
    assign result_ch.median   = median_reg;
    assign result_ch.centre   = centre_reg;

endmodule

`default_nettype wire

>>> rtl/core/rmrf_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module rmrf_cell
    import rmrf_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int IDX_W       = 8,
    parameter int CNT_W       = 8,
    parameter int IDX         = 0
) (
    input  wire logic                          clk,
    input  wire rmrf_ctrl_t                    ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic signed [SAMPLE_BITS-1:0] oldest,
    input  wire logic [IDX_W-1:0]              base,
    input  wire logic [IDX_W-1:0]              old_base,
    input  wire logic [CNT_W-1:0]              fill_end,
    input  wire logic signed [SAMPLE_BITS-1:0] below_val,
    input  wire logic                          below_le_s,
    input  wire logic signed [SAMPLE_BITS-1:0] above_val,
    input  wire logic                          above_le_s,
    input  wire logic                          above_le_old,
    input  wire logic signed [SAMPLE_BITS-1:0] ctap_prev,
    input  wire logic signed [SAMPLE_BITS-1:0] otap_prev,
    output logic signed [SAMPLE_BITS-1:0]      val,
    output logic                               le_s,
    output logic                               le_old,
    output logic signed [SAMPLE_BITS-1:0]      ctap,
    output logic signed [SAMPLE_BITS-1:0]      otap
);

    localparam logic [IDX_W-1:0] POS_I = IDX_W'(IDX);
    localparam logic [CNT_W-1:0] POS_C = CNT_W'(IDX);

    logic signed [SAMPLE_BITS-1:0] val_reg;
    logic signed [SAMPLE_BITS-1:0] val_next;
    logic signed [SAMPLE_BITS-1:0] ctap_reg;
    logic signed [SAMPLE_BITS-1:0] ctap_next;
    logic signed [SAMPLE_BITS-1:0] otap_reg;
    logic signed [SAMPLE_BITS-1:0] otap_next;
    logic                          below_win;
    logic                          above_win;

    // cells under the window count as small, cells over it as large
    assign below_win = POS_I < base;
    assign above_win = POS_C >= fill_end;
    assign le_s      = below_win | (~above_win & (val_reg <= sample));
    assign le_old    = below_win | (~above_win & (val_reg <= oldest));

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.merge_up)
        begin
            // leaving entry sits below the insert point: pull down from above
            if (above_le_old)
                val_next = val_reg;
            else if (above_le_s)
                val_next = above_val;
            else if (le_s)
                val_next = sample;
        end
        else
        begin
            // insert point sits below the leaving entry: push up from below
            if (le_s)
                val_next = val_reg;
            else if (below_le_s)
                val_next = sample;
            else if (le_old | ~ctrl.full)
                val_next = below_val;
        end
    end

    always_comb
    begin
        ctap_next = (POS_I == base) ? sample : ctap_prev;
        otap_next = (POS_I == old_base) ? sample : otap_prev;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            val_reg  <= val_next;
            ctap_reg <= ctap_next;
            otap_reg <= otap_next;
        end
    end

    assign val  = val_reg;
    assign ctap = ctap_reg;
    assign otap = otap_reg;

endmodule

`default_nettype wire

>>> rtl/core/rmrf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rmrf_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic signed [SAMPLE_BITS:0]   residual,
    input wire logic signed [SAMPLE_BITS-1:0] median,
    input wire logic signed [SAMPLE_BITS-1:0] centre
);

    logic                        in_xfer;
    logic signed [SAMPLE_BITS:0] diff_chk;

    assign in_xfer  = in_valid & in_ready;
    assign diff_chk = (SAMPLE_BITS + 1)'(centre) - (SAMPLE_BITS + 1)'(median);

    `CHK_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
    `CHK_ASSERT(a_residual, clk, rst_n, out_valid |-> residual == diff_chk, "residual is not centre minus median")
    `CHK_ASSERT(a_out_cause, clk, rst_n, $rose(out_valid) |-> $past(in_xfer, 2), "result without a sample transfer")
    `CHK_NEVER(a_in_stall, clk, rst_n, !in_ready && !(out_valid && !out_ready), "input stalled with free output")

endmodule

bind running_median_residual_filter rmrf_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_rmrf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (sample_ch.valid),
    .in_ready (sample_ch.ready),
    .out_valid(result_ch.valid),
    .out_ready(result_ch.ready),
    .residual (result_ch.residual),
    .median   (result_ch.median),
    .centre   (result_ch.centre)
);

`default_nettype wire

>>> test/running_median_residual_filter_tb.sv
`timescale 1ns / 1ps

module running_median_residual_filter_tb;
    import rmrf_pkg::*;

    localparam int MAX_SPAN     = 64;
    localparam int DATA_BITS    = 16;
    localparam int ITEM_TARGET  = 1700;
    localparam int DRAIN_CYCLES = 6;

    typedef struct packed {
        logic signed [DATA_BITS:0]   residual;
        logic signed [DATA_BITS-1:0] median;
        logic signed [DATA_BITS-1:0] centre;
    } median_result_t;

    typedef enum logic [1:0] {ROW_SPAN, ROW_SAMPLE, ROW_CHECKED} row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        logic [SPAN_BITS-1:0]        span;
        logic signed [DATA_BITS-1:0] sample;
        logic                        record_start;
        median_result_t              want;
    } drill_row_t;

    logic clk;
    logic rst_n;

    rmrf_sample_if #(.SAMPLE_BITS(DATA_BITS)) sample_ch();
    rmrf_result_if #(.SAMPLE_BITS(DATA_BITS)) result_ch();
    rmrf_cfg_if span_cfg();

    running_median_residual_filter #(
        .MAX_HALF_SPAN(MAX_SPAN),
        .SAMPLE_BITS  (DATA_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample_ch(sample_ch),
        .result_ch(result_ch),
        .span_cfg (span_cfg)
    );

    // predictor state: span register and the window in arrival order
    logic [SPAN_BITS-1:0] span_now;
    int                   window_q[$];

    median_result_t       result_due[$];
    int                   mismatches;
    int                   results_seen;
    bit                   sender_burst;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int span_in_use();
        if (span_now == 0)
            return 1;
        if (span_now > MAX_SPAN)
            return MAX_SPAN;
        return int'(span_now);
    endfunction

    function automatic void slide_window(input int s, input bit rs, output bit has,
                                         output median_result_t r);
        int h;
        int w;
        int pos;
        int ordered[$];
        h = span_in_use();
        w = 2 * h + 1;
        has = 1'b0;
        r = '0;
        if (rs)
            window_q.delete();
        if (window_q.size() >= w)
            void'(window_q.pop_front());
        window_q.push_back(s);
        if (window_q.size() < w)
            return;
        foreach (window_q[i])
        begin
            pos = 0;
            while (pos < ordered.size() && ordered[pos] <= window_q[i])
                pos++;
            ordered.insert(pos, window_q[i]);
        end
        // oldest at index 0, so the centre tap sits h entries in
        r.centre   = 16'(window_q[h]);
        r.median   = 16'(ordered[h]);
        r.residual = 17'(window_q[h] - ordered[h]);
        has = 1'b1;
    endfunction

    function automatic logic signed [DATA_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            1, 2, 3: return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic drill_row_t drill_row(input row_kind_t kind, input int span,
                                             input int s, input bit rs,
                                             input int res, input int med, input int cen);
        drill_row_t row;
        row.kind          = kind;
        row.span          = SPAN_BITS'(span);
        row.sample        = 16'(s);
        row.record_start  = rs;
        row.want.residual = 17'(res);
        row.want.median   = 16'(med);
        row.want.centre   = 16'(cen);
        return row;
    endfunction

    task automatic write_span(input logic [SPAN_BITS-1:0] value);
        sample_ch.valid <= 1'b0;
        while (result_due.size() != 0)
            @(posedge clk);
        // a sample that makes no result may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
        span_cfg.valid     <= 1'b1;
        span_cfg.half_span <= value;
        @(posedge clk);
        while (!span_cfg.ready)
            @(posedge clk);
        span_cfg.valid <= 1'b0;
        span_now = value;
        window_q.delete();
    endtask

    task automatic push_sample(input logic signed [DATA_BITS-1:0] s, input logic rs,
                               input bit typed, input median_result_t want);
        median_result_t got;
        bit             has;
        sample_ch.valid        <= 1'b1;
        sample_ch.sample       <= s;
        sample_ch.record_start <= rs;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        slide_window(int'(s), rs, has, got);
        if (typed)
            result_due.push_back(want);
        else if (has)
            result_due.push_back(got);
    endtask

    task automatic idle_sender();
        int pick;
        int gap;
        pick = $urandom_range(0, 19);
        gap = 0;
        if (!sender_burst)
        begin
            if (pick >= 18)
                gap = $urandom_range(8, 30);
            else if (pick >= 12)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        median_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (result_due.size() == 0)
            begin
                $error("result transfer with nothing expected: residual %0d median %0d",
                       result_ch.residual, result_ch.median);
                mismatches++;
            end
            else
            begin
                want = result_due.pop_front();
                if (result_ch.residual !== want.residual)
                begin
                    $error("residual: expected %0d, got %0d", want.residual,
                           result_ch.residual);
                    mismatches++;
                end
                if (result_ch.median !== want.median)
                begin
                    $error("median: expected %0d, got %0d", want.median, result_ch.median);
                    mismatches++;
                end
                if (result_ch.centre !== want.centre)
                begin
                    $error("centre: expected %0d, got %0d", want.centre, result_ch.centre);
                    mismatches++;
                end
            end
        end
    end

    // result receiver: random ready, bursts, and long hold-offs
    initial
    begin : result_sink
        int hold;
        int run;
        bit eager;
        int next_squeeze;
        hold = 0;
        run = 0;
        eager = 1'b1;
        next_squeeze = 150;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (results_seen >= next_squeeze)
            begin
                // long hold-off so the block backs up and stalls its input
                hold = 300;
                next_squeeze += 700;
            end
            if (hold > 0)
            begin
                result_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                if (run == 0)
                begin
                    eager = ($urandom_range(0, 2) == 0);
                    run = $urandom_range(10, 60);
                end
                run--;
                if (eager)
                    result_ch.ready <= 1'b1;
                else if ($urandom_range(0, 49) == 0)
                begin
                    hold = $urandom_range(10, 40);
                    result_ch.ready <= 1'b0;
                end
                else
                    result_ch.ready <= ($urandom_range(0, 9) < 7);
            end
        end
    end

    initial
    begin : stimulus
        drill_row_t     drill[$];
        median_result_t none;
        logic [SPAN_BITS-1:0] fixed_spans[8];
        logic [SPAN_BITS-1:0] span;
        int             sent;
        int             phase;
        int             n;
        none = '0;
        sent = 0;
        phase = 0;
        mismatches = 0;
        results_seen = 0;
        sender_burst = 1'b0;
        span_now = SPAN_RESET;
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.sample = '0;
        sample_ch.record_start = 1'b0;
        span_cfg.valid = 1'b0;
        span_cfg.half_span = '0;

        fixed_spans = '{7'd127, 7'd65, 7'd64, 7'd30, 7'd35, 7'd1, 7'd0, 7'd3};

        // reset span is 30: three samples must give nothing
        drill.push_back(drill_row(ROW_SAMPLE, 0, 1, 1'b0, 0, 0, 0));
        drill.push_back(drill_row(ROW_SAMPLE, 0, -1, 1'b0, 0, 0, 0));
        drill.push_back(drill_row(ROW_SAMPLE, 0, 2, 1'b0, 0, 0, 0));
        // span 0 is taken as 1: three-point window
        drill.push_back(drill_row(ROW_SPAN, 0, 0, 1'b0, 0, 0, 0));
        drill.push_back(drill_row(ROW_SAMPLE, 0, 32767, 1'b0, 0, 0, 0));
        drill.push_back(drill_row(ROW_SAMPLE, 0, -32768, 1'b0, 0, 0, 0));
        drill.push_back(drill_row(ROW_CHECKED, 0, 0, 1'b0, -32768, 0, -32768));
        drill.push_back(drill_row(ROW_CHECKED, 0, 32767, 1'b0, 0, 0, 0));
        // full-scale residuals in both directions
        drill.push_back(drill_row(ROW_SAMPLE, 0, -32768, 1'b1, 0, 0, 0));
        drill.push_back(drill_row(ROW_SAMPLE, 0, 32767, 1'b0, 0, 0, 0));
        drill.push_back(drill_row(ROW_CHECKED, 0, -32768, 1'b0, 65535, -32768, 32767));
        drill.push_back(drill_row(ROW_CHECKED, 0, 32767, 1'b0, -65535, 32767, -32768));
        // equal values in the window, then a new record mid-stream
        drill.push_back(drill_row(ROW_SPAN, 1, 0, 1'b0, 0, 0, 0));
        drill.push_back(drill_row(ROW_SAMPLE, 0, 7, 1'b0, 0, 0, 0));
        drill.push_back(drill_row(ROW_SAMPLE, 0, 7, 1'b0, 0, 0, 0));
        drill.push_back(drill_row(ROW_SAMPLE, 0, -3, 1'b0, 0, 0, 0));
        drill.push_back(drill_row(ROW_SAMPLE, 0, 9, 1'b0, 0, 0, 0));
        drill.push_back(drill_row(ROW_SAMPLE, 0, 7, 1'b1, 0, 0, 0));
        drill.push_back(drill_row(ROW_SAMPLE, 0, 0, 1'b0, 0, 0, 0));
        drill.push_back(drill_row(ROW_SAMPLE, 0, -1, 1'b0, 0, 0, 0));
        // five-point window
        drill.push_back(drill_row(ROW_SPAN, 2, 0, 1'b0, 0, 0, 0));
        drill.push_back(drill_row(ROW_SAMPLE, 0, 100, 1'b0, 0, 0, 0));
        drill.push_back(drill_row(ROW_SAMPLE, 0, -100, 1'b0, 0, 0, 0));
        drill.push_back(drill_row(ROW_SAMPLE, 0, 50, 1'b0, 0, 0, 0));
        drill.push_back(drill_row(ROW_SAMPLE, 0, -50, 1'b0, 0, 0, 0));
        drill.push_back(drill_row(ROW_SAMPLE, 0, 0, 1'b0, 0, 0, 0));
        drill.push_back(drill_row(ROW_SAMPLE, 0, 1, 1'b0, 0, 0, 0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (drill[i])
        begin
            case (drill[i].kind)
                ROW_SPAN: write_span(drill[i].span);
                ROW_SAMPLE:
                begin
                    push_sample(drill[i].sample, drill[i].record_start, 1'b0, none);
                    idle_sender();
                end
                default:
                begin
                    push_sample(drill[i].sample, drill[i].record_start, 1'b1, drill[i].want);
                    idle_sender();
                end
            endcase
        end

        // random phases: fixed spans first, extremes among them, then mostly small spans
        while (sent < ITEM_TARGET)
        begin
            if (phase < 8)
                span = fixed_spans[phase];
            else if ($urandom_range(0, 3) == 0)
                span = SPAN_BITS'($urandom_range(0, 127));
            else
                span = SPAN_BITS'($urandom_range(0, 10));
            write_span(span);
            n = 2 * span_in_use() + 1 + $urandom_range(20, 120);
            sender_burst = ($urandom_range(0, 3) == 0);
            repeat (n)
            begin
                push_sample(pick_sample(), ($urandom_range(0, 49) == 0), 1'b0, none);
                sent++;
                idle_sender();
            end
            phase++;
        end

        sample_ch.valid <= 1'b0;
        while (result_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("[running_median_residual_filter] OK");
        else
            $display("[running_median_residual_filter] ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("[running_median_residual_filter] ERROR");
        $finish;
    end

endmodule
